/* rtl/core/tztl_pkg.sv */
// Shared widths, operation codes, status codes and register indexes of the time zone lookup.
package tztl_pkg;

    localparam int TIME_W     = 64;
    localparam int OFF_W      = 18;
    localparam int ABV_W      = 8;
    localparam int CORR_W     = 13;
    localparam int IDX_W      = 8;
    localparam int STAT_W     = 3;
    localparam int OP_W       = 3;
    localparam int POL_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int TC_W       = 9;
    localparam int YC_W       = 5;
    localparam int LC_W       = 6;

    localparam logic [OP_W-1:0] OP_WR_TRANS    = 3'd0;
    localparam logic [OP_W-1:0] OP_WR_TYPE     = 3'd1;
    localparam logic [OP_W-1:0] OP_WR_LEAP     = 3'd2;
    localparam logic [OP_W-1:0] OP_TO_LOCAL    = 3'd3;
    localparam logic [OP_W-1:0] OP_TO_UTC      = 3'd4;
    localparam logic [OP_W-1:0] OP_PREV_CHANGE = 3'd5;
    localparam logic [OP_W-1:0] OP_NEXT_CHANGE = 3'd6;
    localparam logic [OP_W-1:0] OP_RESERVED    = 3'd7;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_INVALID   = 3'd1;
    localparam logic [STAT_W-1:0] ST_AMBIGUOUS = 3'd2;
    localparam logic [STAT_W-1:0] ST_NO_CHANGE = 3'd3;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 3'd4;

    localparam logic [POL_W-1:0] POL_STRICT  = 2'd0;
    localparam logic [POL_W-1:0] POL_EARLIER = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_TRANS_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAP_COUNT  = 2'd2;

endpackage

/* rtl/core/tztl_if.sv */
// Request and result channel interfaces of the time zone lookup.
interface tztl_in_if;
    logic                                valid;
    logic                                ready;
    logic [tztl_pkg::OP_W-1:0]           opcode;
    logic [tztl_pkg::IDX_W-1:0]          entry_index;
    logic signed [tztl_pkg::TIME_W-1:0]  time_value;
    logic [tztl_pkg::IDX_W-1:0]          type_select;
    logic signed [tztl_pkg::OFF_W-1:0]   offset_in;
    logic                                dst_in;
    logic [tztl_pkg::ABV_W-1:0]          abbrev_in;
    logic signed [tztl_pkg::CORR_W-1:0]  correction_in;
    logic [tztl_pkg::POL_W-1:0]          utc_policy;
    logic                                local_flag;

    modport source(output valid, opcode, entry_index, time_value, type_select, offset_in,
                   dst_in, abbrev_in, correction_in, utc_policy, local_flag, input ready);
    modport sink(input valid, opcode, entry_index, time_value, type_select, offset_in,
                 dst_in, abbrev_in, correction_in, utc_policy, local_flag, output ready);
endinterface

interface tztl_out_if;
    logic                                valid;
    logic                                ready;
    logic [tztl_pkg::STAT_W-1:0]         status;
    logic signed [tztl_pkg::TIME_W-1:0]  time_out;
    logic signed [tztl_pkg::OFF_W-1:0]   offset_out;
    logic                                dst_out;
    logic [tztl_pkg::ABV_W-1:0]          abbrev_out;
    logic signed [tztl_pkg::CORR_W-1:0]  leap_out;

    modport source(output valid, status, time_out, offset_out, dst_out, abbrev_out, leap_out,
                   input ready);
    modport sink(input valid, status, time_out, offset_out, dst_out, abbrev_out, leap_out,
                 output ready);
endinterface

/* rtl/core/time_zone_transition_lookup_unit.sv */
// Time zone transition lookup: table stores in synchronous memories and a scanning sequencer.
// One request beat is taken at a time, and the next one only once the result of the last has
// been loaded into the output register. A table write, or an answer that is settled when the
// request is taken, goes straight to the done state and is loaded from there. A query streams
// the transition memory one entry per cycle through a three-stage read pipeline (entry read,
// type read, offset subtract) until it decides; a conversion to local time then streams the
// leap memory too when the leap count is nonzero. Every successful query answer ends with one
// type memory read. A result that is held until the receiver takes it holds back the loading
// of the next result.
module time_zone_transition_lookup_unit #(
    parameter int MAX_TRANSITIONS = 256,
    parameter int MAX_TYPES       = 16,
    parameter int MAX_LEAPS       = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    tztl_in_if.sink                             i_in,
    tztl_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [tztl_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tztl_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int TAW  = $clog2(MAX_TRANSITIONS);
    localparam int TCW  = $clog2(MAX_TRANSITIONS + 1);
    localparam int TYW  = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
    localparam int YCW  = $clog2(MAX_TYPES + 1);
    localparam int LAW  = (MAX_LEAPS > 1) ? $clog2(MAX_LEAPS) : 1;
    localparam int LCW  = $clog2(MAX_LEAPS + 1);
    localparam int TW   = tztl_pkg::TIME_W;
    localparam int OW   = tztl_pkg::OFF_W;
    localparam int CW   = tztl_pkg::CORR_W;
    localparam int AW   = tztl_pkg::ABV_W;

    typedef enum logic [2:0] {S_IDLE, S_TSCAN, S_LSCAN, S_TYRD, S_DONE} t_state;
    typedef enum logic [1:0] {OM_NONE, OM_ADD, OM_SUB} t_omode;

    logic [TW-1:0]  m_ttime [MAX_TRANSITIONS];
    logic [TYW-1:0] m_ttype [MAX_TRANSITIONS];
    logic [OW-1:0]  m_off   [MAX_TYPES];
    logic           m_dst   [MAX_TYPES];
    logic [AW-1:0]  m_abv   [MAX_TYPES];
    logic [TW-1:0]  m_ltime [MAX_LEAPS];
    logic [CW-1:0]  m_lcorr [MAX_LEAPS];

    t_state                      r_state;
    logic [TCW-1:0]              r_tc;
    logic [YCW-1:0]              r_yc;
    logic [LCW-1:0]              r_lc;
    logic [tztl_pkg::OP_W-1:0]   r_op;
    logic [TW-1:0]               r_t;
    logic [tztl_pkg::POL_W-1:0]  r_policy;
    logic                        r_local;

    logic [TCW-1:0]  r_iss;
    logic            r_v1, r_v2, r_v3;
    logic            r_f1, r_f2, r_f3;
    logic            r_l1, r_l2, r_l3;
    logic [TW-1:0]   r_q_time, r_time2, r_time3, r_u3;
    logic [TYW-1:0]  r_q_type, r_type2, r_type3;
    logic [TW-1:0]   r_ptime, r_pu;
    logic [TYW-1:0]  r_ptype;
    logic [OW-1:0]   r_y_off;
    logic            r_y_dst;
    logic [AW-1:0]   r_y_abv;

    logic [LCW-1:0]  r_liss;
    logic            r_lv1, r_ll1;
    logic [TW-1:0]   r_lq_time;
    logic [CW-1:0]   r_lq_corr;
    logic [CW-1:0]   r_leap;

    logic [TYW-1:0]                r_sel;
    logic [TW-1:0]                 r_base;
    t_omode                        r_mode;
    logic                          r_zero;
    logic [tztl_pkg::STAT_W-1:0]   r_status;

    logic                          r_ov;
    logic [tztl_pkg::STAT_W-1:0]   r_o_status;
    logic [TW-1:0]                 r_o_time;
    logic [OW-1:0]                 r_o_off;
    logic                          r_o_dst;
    logic [AW-1:0]                 r_o_abv;
    logic [CW-1:0]                 r_o_leap;

    logic [31:0]     idx32;
    logic            wr_t_ok, wr_y_ok, wr_l_ok, acc;
    logic            tscan, lscan, t_issue, l_issue, l_gt;
    logic [TAW-1:0]  t_rd_addr;
    logic [TYW-1:0]  y_rd_addr;
    logic [LAW-1:0]  l_rd_addr;
    logic [TW-1:0]   y_offx, res_time;
    logic [TCW-1:0]  n_tc;
    logic [YCW-1:0]  n_yc;
    logic [LCW-1:0]  n_lc;

    logic                          e_dec, e_zero;
    logic [tztl_pkg::STAT_W-1:0]   e_st;
    logic [TYW-1:0]                e_sel;
    logic [TW-1:0]                 e_base;
    t_omode                        e_mode;
    logic                          gt_ct, gt_cpu, gt_ppu, gt_cuu, pbad, cbad;

    t_state                        a_state;
    t_omode                        a_mode;
    logic                          a_zero;
    logic [tztl_pkg::STAT_W-1:0]   a_status;

    assign acc     = i_in.valid && (r_state == S_IDLE);
    assign idx32   = 32'(i_in.entry_index);
    assign wr_t_ok = (idx32 < 32'(MAX_TRANSITIONS)) && (32'(i_in.type_select) < 32'(MAX_TYPES));
    assign wr_y_ok = idx32 < 32'(MAX_TYPES);
    assign wr_l_ok = idx32 < 32'(MAX_LEAPS);

    assign tscan     = (r_state == S_TSCAN);
    assign lscan     = (r_state == S_LSCAN);
    assign t_issue   = tscan && !e_dec && (32'(r_iss) < 32'(r_tc));
    assign l_issue   = lscan && (32'(r_liss) < 32'(r_lc));
    assign t_rd_addr = r_iss[TAW-1:0];
    assign l_rd_addr = r_liss[LAW-1:0];
    assign y_rd_addr = tscan ? r_q_type : r_sel;
    assign y_offx    = {{(TW-OW){r_y_off[OW-1]}}, r_y_off};
    assign l_gt      = $signed(r_lq_time) > $signed(r_t);

    assign n_tc = (32'(i_cfg_data) < 32'(MAX_TRANSITIONS)) ? TCW'(i_cfg_data)
                                                           : TCW'(MAX_TRANSITIONS);
    assign n_yc = (32'(i_cfg_data[tztl_pkg::YC_W-1:0]) < 32'(MAX_TYPES))
                  ? YCW'(i_cfg_data[tztl_pkg::YC_W-1:0]) : YCW'(MAX_TYPES);
    assign n_lc = (32'(i_cfg_data[tztl_pkg::LC_W-1:0]) < 32'(MAX_LEAPS))
                  ? LCW'(i_cfg_data[tztl_pkg::LC_W-1:0]) : LCW'(MAX_LEAPS);

    always_ff @(posedge i_clk) begin
        if (acc && (i_in.opcode == tztl_pkg::OP_WR_TRANS) && wr_t_ok) begin
            m_ttime[idx32[TAW-1:0]] <= i_in.time_value;
            m_ttype[idx32[TAW-1:0]] <= i_in.type_select[TYW-1:0];
        end
        r_q_time <= m_ttime[t_rd_addr];
        r_q_type <= m_ttype[t_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (acc && (i_in.opcode == tztl_pkg::OP_WR_TYPE) && wr_y_ok) begin
            m_off[idx32[TYW-1:0]] <= i_in.offset_in;
            m_dst[idx32[TYW-1:0]] <= i_in.dst_in;
            m_abv[idx32[TYW-1:0]] <= i_in.abbrev_in;
        end
        r_y_off <= m_off[y_rd_addr];
        r_y_dst <= m_dst[y_rd_addr];
        r_y_abv <= m_abv[y_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (acc && (i_in.opcode == tztl_pkg::OP_WR_LEAP) && wr_l_ok) begin
            m_ltime[idx32[LAW-1:0]] <= i_in.time_value;
            m_lcorr[idx32[LAW-1:0]] <= i_in.correction_in;
        end
        r_lq_time <= m_ltime[l_rd_addr];
        r_lq_corr <= m_lcorr[l_rd_addr];
    end

    always_comb begin
        a_state  = S_DONE;
        a_mode   = OM_NONE;
        a_zero   = 1'b1;
        a_status = tztl_pkg::ST_OK;
        case (i_in.opcode)
            tztl_pkg::OP_WR_TRANS: begin
                if (!wr_t_ok) a_status = tztl_pkg::ST_BAD_INDEX;
            end
            tztl_pkg::OP_WR_TYPE: begin
                if (!wr_y_ok) a_status = tztl_pkg::ST_BAD_INDEX;
            end
            tztl_pkg::OP_WR_LEAP: begin
                if (!wr_l_ok) a_status = tztl_pkg::ST_BAD_INDEX;
            end
            tztl_pkg::OP_TO_LOCAL: begin
                a_mode = OM_ADD;
                if (r_tc != '0) begin
                    a_zero  = 1'b0;
                    a_state = S_TSCAN;
                end else if (r_yc == '0) begin
                    a_status = tztl_pkg::ST_BAD_INDEX;
                end else begin
                    a_zero  = 1'b0;
                    a_state = (r_lc == '0) ? S_TYRD : S_LSCAN;
                end
            end
            tztl_pkg::OP_TO_UTC: begin
                a_mode = OM_SUB;
                if (r_tc != '0) begin
                    a_zero  = 1'b0;
                    a_state = S_TSCAN;
                end else if (r_yc == '0) begin
                    a_status = tztl_pkg::ST_BAD_INDEX;
                end else begin
                    a_zero  = 1'b0;
                    a_state = S_TYRD;
                end
            end
            tztl_pkg::OP_PREV_CHANGE, tztl_pkg::OP_NEXT_CHANGE: begin
                if (32'(r_tc) < 32'd2) begin
                    a_status = tztl_pkg::ST_NO_CHANGE;
                end else begin
                    a_zero  = 1'b0;
                    a_state = S_TSCAN;
                end
            end
            default: begin
                a_status = tztl_pkg::ST_BAD_INDEX;
            end
        endcase
    end

    always_comb begin
        e_dec  = 1'b0;
        e_zero = 1'b0;
        e_st   = tztl_pkg::ST_OK;
        e_sel  = r_type3;
        e_base = r_t;
        e_mode = OM_NONE;
        gt_ct  = $signed(r_time3) > $signed(r_t);
        gt_cpu = $signed(r_time3) > $signed(r_pu);
        gt_ppu = $signed(r_ptime) > $signed(r_pu);
        gt_cuu = $signed(r_time3) > $signed(r_u3);
        pbad   = 32'(r_ptype) >= 32'(r_yc);
        cbad   = 32'(r_type3) >= 32'(r_yc);
        if (tscan && r_v3) begin
            case (r_op)
                tztl_pkg::OP_TO_LOCAL: begin
                    e_mode = OM_ADD;
                    if (gt_ct) begin
                        e_dec = 1'b1;
                        e_sel = r_f3 ? '0 : r_ptype;
                    end else if (r_l3) begin
                        e_dec = 1'b1;
                    end
                    if (e_dec && (32'(e_sel) >= 32'(r_yc))) begin
                        e_zero = 1'b1;
                        e_st   = tztl_pkg::ST_BAD_INDEX;
                    end
                end
                tztl_pkg::OP_TO_UTC: begin
                    e_mode = OM_SUB;
                    if (!r_f3 && pbad) begin
                        e_dec  = 1'b1;
                        e_zero = 1'b1;
                        e_st   = tztl_pkg::ST_BAD_INDEX;
                    end else if (!r_f3 && gt_cpu) begin
                        e_dec = 1'b1;
                        e_sel = r_ptype;
                        if (gt_ppu) begin
                            e_zero = 1'b1;
                            e_st   = tztl_pkg::ST_INVALID;
                        end else if (r_policy == tztl_pkg::POL_EARLIER) begin
                            e_sel = r_ptype;
                        end else if (cbad) begin
                            e_zero = 1'b1;
                            e_st   = tztl_pkg::ST_BAD_INDEX;
                        end else if (!gt_cuu) begin
                            if (r_policy == tztl_pkg::POL_STRICT) begin
                                e_zero = 1'b1;
                                e_st   = tztl_pkg::ST_AMBIGUOUS;
                            end else begin
                                e_sel = r_type3;
                            end
                        end
                    end else if (r_l3) begin
                        e_dec = 1'b1;
                        if (cbad) begin
                            e_zero = 1'b1;
                            e_st   = tztl_pkg::ST_BAD_INDEX;
                        end
                    end
                end
                tztl_pkg::OP_PREV_CHANGE, tztl_pkg::OP_NEXT_CHANGE: begin
                    if (!r_f3 && gt_ct) begin
                        e_dec = 1'b1;
                        if (pbad) begin
                            e_zero = 1'b1;
                            e_st   = tztl_pkg::ST_BAD_INDEX;
                        end else begin
                            e_sel  = r_ptype;
                            e_base = (r_op == tztl_pkg::OP_PREV_CHANGE) ? r_ptime : r_time3;
                            e_mode = r_local ? OM_ADD : OM_NONE;
                        end
                    end else if (r_l3) begin
                        e_dec  = 1'b1;
                        e_zero = 1'b1;
                        e_st   = tztl_pkg::ST_NO_CHANGE;
                    end
                end
                default: begin
                    e_dec = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        case (r_mode)
            OM_ADD:  res_time = r_base + y_offx;
            OM_SUB:  res_time = r_base - y_offx;
            default: res_time = r_base;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_tc    <= '0;
            r_yc    <= '0;
            r_lc    <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_lv1   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tztl_pkg::CFG_TRANS_COUNT: r_tc <= n_tc;
                    tztl_pkg::CFG_TYPE_COUNT:  r_yc <= n_yc;
                    tztl_pkg::CFG_LEAP_COUNT:  r_lc <= n_lc;
                    default:                   r_tc <= r_tc;
                endcase
            end

            r_v1 <= t_issue;
            r_f1 <= (r_iss == '0);
            r_l1 <= (32'(r_iss) + 32'd1) == 32'(r_tc);
            if (t_issue) begin
                r_iss <= r_iss + TCW'(1);
            end
            r_v2    <= r_v1 && tscan;
            r_f2    <= r_f1;
            r_l2    <= r_l1;
            r_time2 <= r_q_time;
            r_type2 <= r_q_type;
            r_v3    <= r_v2 && tscan;
            r_f3    <= r_f2;
            r_l3    <= r_l2;
            r_time3 <= r_time2;
            r_type3 <= r_type2;
            r_u3    <= r_t - y_offx;
            if (tscan && r_v3 && !e_dec) begin
                r_ptime <= r_time3;
                r_ptype <= r_type3;
                r_pu    <= r_u3;
            end

            r_lv1 <= l_issue;
            r_ll1 <= (32'(r_liss) + 32'd1) == 32'(r_lc);
            if (l_issue) begin
                r_liss <= r_liss + LCW'(1);
            end

            if (o_out.ready && (r_state != S_DONE)) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_op     <= i_in.opcode;
                        r_t      <= i_in.time_value;
                        r_policy <= i_in.utc_policy;
                        r_local  <= i_in.local_flag;
                        r_iss    <= '0;
                        r_liss   <= '0;
                        r_leap   <= '0;
                        r_sel    <= '0;
                        r_base   <= i_in.time_value;
                        r_mode   <= a_mode;
                        r_zero   <= a_zero;
                        r_status <= a_status;
                        r_state  <= a_state;
                    end
                end
                S_TSCAN: begin
                    if (e_dec) begin
                        r_sel    <= e_sel;
                        r_base   <= e_base;
                        r_mode   <= e_mode;
                        r_zero   <= e_zero;
                        r_status <= e_st;
                        if (e_zero) begin
                            r_state <= S_DONE;
                        end else if (r_op == tztl_pkg::OP_TO_LOCAL) begin
                            r_state <= (r_lc == '0) ? S_TYRD : S_LSCAN;
                        end else begin
                            r_state <= S_TYRD;
                        end
                    end
                end
                S_LSCAN: begin
                    if (r_lv1) begin
                        if (l_gt) begin
                            r_state <= S_TYRD;
                        end else begin
                            r_leap <= r_lq_corr;
                            if (r_ll1) begin
                                r_state <= S_TYRD;
                            end
                        end
                    end
                end
                S_TYRD: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ov || o_out.ready) begin
                        r_ov       <= 1'b1;
                        r_o_status <= r_status;
                        r_o_time   <= r_zero ? '0 : res_time;
                        r_o_off    <= r_zero ? '0 : r_y_off;
                        r_o_dst    <= r_zero ? 1'b0 : r_y_dst;
                        r_o_abv    <= r_zero ? '0 : r_y_abv;
                        r_o_leap   <= r_zero ? '0 : r_leap;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_ov;
    assign o_out.status     = r_o_status;
    assign o_out.time_out   = r_o_time;
    assign o_out.offset_out = r_o_off;
    assign o_out.dst_out    = r_o_dst;
    assign o_out.abbrev_out = r_o_abv;
    assign o_out.leap_out   = r_o_leap;

endmodule
